// File: rtl/blpq_pkg.sv
`default_nettype none

package blpq_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned EvW  = 4;

  // event codes
  localparam logic [EvW-1:0] EV_NONE       = 4'd0;
  localparam logic [EvW-1:0] EV_BACK       = 4'd1;
  localparam logic [EvW-1:0] EV_MENU       = 4'd2;
  localparam logic [EvW-1:0] EV_UP         = 4'd3;
  localparam logic [EvW-1:0] EV_DOWN       = 4'd4;
  localparam logic [EvW-1:0] EV_LONG_BACK  = 4'd5;
  localparam logic [EvW-1:0] EV_LONG_MENU  = 4'd6;
  localparam logic [EvW-1:0] EV_LONG_UP    = 4'd7;
  localparam logic [EvW-1:0] EV_LONG_DOWN  = 4'd8;

  localparam logic [1:0] BTN_BACK = 2'd0;
  localparam logic [1:0] BTN_MENU = 2'd1;
  localparam logic [1:0] BTN_UP   = 2'd2;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_CONSUME = 1'b1;

  localparam logic CFG_LONG  = 1'b0;
  localparam logic CFG_STUCK = 1'b1;

  localparam logic [CntW-1:0] LONG_RST  = 16'd100;
  localparam logic [CntW-1:0] STUCK_RST = 16'd1000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TIMING,
    PH_WAIT
  } phase_e;

  typedef enum logic [1:0] {
    CM_NON_BACK,
    CM_BACK_ONLY,
    CM_ANY,
    CM_DISCARD
  } cmode_e;

  typedef enum logic [1:0] {
    PULSE_NONE,
    PULSE_SHORT,
    PULSE_LONG
  } pulse_e;

  typedef struct packed {
    logic       kind;
    logic [3:0] button_levels;
    cmode_e     consume_mode;
  } in_item_t;

  typedef struct packed {
    logic [EvW-1:0] consumed_event;
    logic [EvW-1:0] pending_event;
    pulse_e         post_pulse;
    logic           stuck_alarm;
    logic           busy_res;
  } res_item_t;

  function automatic logic is_back_ev(input logic [EvW-1:0] m);
    return (m == EV_BACK) || (m == EV_LONG_BACK);
  endfunction

  // a pending event of a higher priority button, or a pending long event of the same button, holds off a new press
  function automatic logic start_blocked(input logic [1:0] b, input logic [EvW-1:0] m);
    logic r;
    unique case (b)
      BTN_BACK: r = (m == EV_LONG_BACK);
      BTN_MENU: r = (m == EV_BACK) || (m == EV_LONG_BACK) || (m == EV_LONG_MENU);
      BTN_UP:   r = (m == EV_MENU) || (m == EV_BACK) || (m == EV_LONG_BACK) ||
                    (m == EV_LONG_MENU) || (m == EV_LONG_UP);
      default:  r = (m == EV_UP) || (m == EV_MENU) || (m == EV_BACK) ||
                    (m == EV_LONG_UP) || (m == EV_LONG_BACK) ||
                    (m == EV_LONG_DOWN) || (m == EV_LONG_MENU);
    endcase
    return r;
  endfunction

  function automatic logic [EvW-1:0] short_ev(input logic [1:0] b);
    return {2'b00, b} + EV_BACK;
  endfunction

  function automatic logic [EvW-1:0] long_ev(input logic [1:0] b);
    return {2'b00, b} + EV_LONG_BACK;
  endfunction

endpackage

`default_nettype wire

// File: rtl/blpq_in_if.sv
`default_nettype none

interface blpq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] button_levels;
  logic [1:0] consume_mode;

  modport source (output valid, kind, button_levels, consume_mode, input ready);
  modport sink   (input valid, kind, button_levels, consume_mode, output ready);
endinterface

`default_nettype wire

// File: rtl/blpq_out_if.sv
`default_nettype none

interface blpq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] consumed_event;
  logic [3:0] pending_event;
  logic [1:0] post_pulse;
  logic       stuck_alarm;
  logic       busy_res;

  modport source (output valid, consumed_event, pending_event, post_pulse, stuck_alarm,
                  busy_res, input ready);
  modport sink   (input valid, consumed_event, pending_event, post_pulse, stuck_alarm,
                  busy_res, output ready);
endinterface

`default_nettype wire

// File: rtl/blpq_core.sv
`default_nettype none

module blpq_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             step_i,
  input  wire  blpq_pkg::in_item_t        item_i,
  input  wire  [blpq_pkg::CntW-1:0]       long_ticks_i,
  input  wire  [blpq_pkg::CntW-1:0]       stuck_ticks_i,
  output blpq_pkg::res_item_t             res_o
);

  blpq_pkg::phase_e            phase_q, phase_d;
  logic [1:0]                  act_q, act_d;
  logic [blpq_pkg::CntW-1:0]   hold_q, hold_d;
  logic [blpq_pkg::EvW-1:0]    mb_q, mb_d;

  logic [blpq_pkg::CntW-1:0]   hold_inc;
  logic [3:0]                  cand;
  logic [1:0]                  sel;
  logic                        held;
  logic                        backish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= blpq_pkg::PH_IDLE;
      act_q   <= '0;
      hold_q  <= '0;
      mb_q    <= blpq_pkg::EV_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      act_q   <= act_d;
      hold_q  <= hold_d;
      mb_q    <= mb_d;
    end
  end

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      cand[b] = item_i.button_levels[b] & ~blpq_pkg::start_blocked(2'(b), mb_q);
    end
    sel = '0;
    for (int b = 3; b >= 0; b--) begin
      if (cand[b]) begin
        sel = 2'(b);
      end
    end
  end

  assign hold_inc = (hold_q == '1) ? hold_q : hold_q + 16'd1;
  assign held     = item_i.button_levels[act_q];
  assign backish  = blpq_pkg::is_back_ev(mb_q);

  always_comb begin
    phase_d = phase_q;
    act_d   = act_q;
    hold_d  = hold_q;
    mb_d    = mb_q;
    res_o.consumed_event = blpq_pkg::EV_NONE;
    res_o.post_pulse     = blpq_pkg::PULSE_NONE;
    res_o.stuck_alarm    = 1'b0;

    if (item_i.kind == blpq_pkg::KIND_CONSUME) begin
      // an unused phase code reads as idle
      if (phase_q != blpq_pkg::PH_TIMING && phase_q != blpq_pkg::PH_WAIT) begin
        phase_d = blpq_pkg::PH_IDLE;
      end
      case (item_i.consume_mode)
        blpq_pkg::CM_NON_BACK: begin
          if (!backish) begin
            res_o.consumed_event = mb_q;
            mb_d = blpq_pkg::EV_NONE;
          end
        end
        blpq_pkg::CM_BACK_ONLY: begin
          if (backish) begin
            res_o.consumed_event = mb_q;
            mb_d = blpq_pkg::EV_NONE;
          end
        end
        blpq_pkg::CM_ANY: begin
          res_o.consumed_event = mb_q;
          mb_d = blpq_pkg::EV_NONE;
        end
        default: begin
          if (!backish) begin
            mb_d = blpq_pkg::EV_NONE;
          end
        end
      endcase
    end else begin
      unique case (phase_q)
        blpq_pkg::PH_TIMING: begin
          if (!held) begin
            mb_d             = blpq_pkg::short_ev(act_q);
            res_o.post_pulse = blpq_pkg::PULSE_SHORT;
            hold_d           = '0;
            phase_d          = blpq_pkg::PH_IDLE;
          end else if (hold_inc >= long_ticks_i) begin
            mb_d             = blpq_pkg::long_ev(act_q);
            res_o.post_pulse = blpq_pkg::PULSE_LONG;
            hold_d           = '0;
            phase_d          = blpq_pkg::PH_WAIT;
          end else begin
            hold_d = hold_inc;
          end
        end
        blpq_pkg::PH_WAIT: begin
          if (!held) begin
            hold_d  = '0;
            phase_d = blpq_pkg::PH_IDLE;
          end else if (hold_inc >= stuck_ticks_i) begin
            res_o.stuck_alarm = 1'b1;
            hold_d            = '0;
            phase_d           = blpq_pkg::PH_IDLE;
          end else begin
            hold_d = hold_inc;
          end
        end
        default: begin
          phase_d = blpq_pkg::PH_IDLE;
          if (|cand) begin
            act_d = sel;
            if (long_ticks_i <= 16'd1) begin
              mb_d             = blpq_pkg::long_ev(sel);
              res_o.post_pulse = blpq_pkg::PULSE_LONG;
              hold_d           = '0;
              phase_d          = blpq_pkg::PH_WAIT;
            end else begin
              hold_d  = 16'd1;
              phase_d = blpq_pkg::PH_TIMING;
            end
          end
        end
      endcase
    end

    res_o.pending_event = mb_d;
    res_o.busy_res      = (phase_d != blpq_pkg::PH_IDLE);
  end

endmodule

`default_nettype wire

// File: rtl/button_long_press_qualifier.sv
// Qualifies Back/Menu/Up/Down levels into short and long press events held in a
// one-entry mailbox. Every input transfer (a tick or a consume request) gives exactly
// one result transfer. A transfer can be taken in every cycle unless the result output
// is stalled while the input register is full. An item passes the input register, then
// the result register, with the compare, saturating count and priority choice between
// them. The user must write both thresholds through the cfg port only while no item
// is in flight; the block itself does not enforce it.
`default_nettype none

module button_long_press_qualifier (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  blpq_in_if.sink                     in_chan,
  blpq_out_if.source                  out_chan,
  input  wire                         cfg_we_i,
  input  wire                         cfg_idx_i,
  input  wire  [blpq_pkg::CntW-1:0]   cfg_data_i
);

  logic                        in_vld_q;
  blpq_pkg::in_item_t          in_q;
  logic                        out_vld_q;
  blpq_pkg::res_item_t         out_q;
  blpq_pkg::res_item_t         res;
  logic [blpq_pkg::CntW-1:0]   long_q;
  logic [blpq_pkg::CntW-1:0]   stuck_q;
  logic                        adv;
  logic                        in_take;

  assign adv      = in_vld_q && (!out_vld_q || out_chan.ready);
  assign in_chan.ready = !in_vld_q || adv;
  assign in_take  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q  <= blpq_pkg::LONG_RST;
      stuck_q <= blpq_pkg::STUCK_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == blpq_pkg::CFG_LONG) begin
        long_q <= cfg_data_i;
      end else begin
        stuck_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_vld_q <= in_chan.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.kind          <= in_chan.kind;
      in_q.button_levels <= in_chan.button_levels;
      in_q.consume_mode  <= blpq_pkg::cmode_e'(in_chan.consume_mode);
    end
    if (adv) begin
      out_q <= res;
    end
  end

  blpq_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (adv),
    .item_i        (in_q),
    .long_ticks_i  (long_q),
    .stuck_ticks_i (stuck_q),
    .res_o         (res)
  );

  assign out_chan.valid          = out_vld_q;
  assign out_chan.consumed_event = out_q.consumed_event;
  assign out_chan.pending_event  = out_q.pending_event;
  assign out_chan.post_pulse     = out_q.post_pulse;
  assign out_chan.stuck_alarm    = out_q.stuck_alarm;
  assign out_chan.busy_res       = out_q.busy_res;

endmodule

`default_nettype wire

// File: rtl/blpq_checker.sv
`default_nettype none

module blpq_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [3:0] consumed_event_i,
  input wire [3:0] pending_event_i,
  input wire [1:0] post_pulse_i,
  input wire       stuck_alarm_i,
  input wire       busy_res_i
);

  // stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({consumed_event_i, pending_event_i, post_pulse_i, stuck_alarm_i, busy_res_i}))
    else $error("result changed while stalled");

  a_short_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && post_pulse_i == blpq_pkg::PULSE_SHORT |->
      pending_event_i >= blpq_pkg::EV_BACK && pending_event_i <= blpq_pkg::EV_DOWN &&
      !busy_res_i)
    else $error("short post without short event in mailbox");

  a_long_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && post_pulse_i == blpq_pkg::PULSE_LONG |->
      pending_event_i >= blpq_pkg::EV_LONG_BACK &&
      pending_event_i <= blpq_pkg::EV_LONG_DOWN && busy_res_i)
    else $error("long post without long event or wait");

  a_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stuck_alarm_i |-> !busy_res_i && post_pulse_i == blpq_pkg::PULSE_NONE &&
      consumed_event_i == blpq_pkg::EV_NONE)
    else $error("stuck alarm with other activity");

  a_consume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && consumed_event_i != blpq_pkg::EV_NONE |->
      pending_event_i == blpq_pkg::EV_NONE && post_pulse_i == blpq_pkg::PULSE_NONE &&
      consumed_event_i <= blpq_pkg::EV_LONG_DOWN)
    else $error("consume left mailbox full");

endmodule

bind button_long_press_qualifier blpq_checker u_blpq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_chan.valid),
  .out_ready_i      (out_chan.ready),
  .consumed_event_i (out_chan.consumed_event),
  .pending_event_i  (out_chan.pending_event),
  .post_pulse_i     (out_chan.post_pulse),
  .stuck_alarm_i    (out_chan.stuck_alarm),
  .busy_res_i       (out_chan.busy_res)
);

`default_nettype wire
